FILE: hdl/fojtk_pkg.sv
`default_nettype none

package fojtk_pkg;

    localparam int unsigned MAX_RESULTS = 24;
    localparam int unsigned NW          = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_RUN    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        SCAN_MATCH,
        SCAN_A,
        SCAN_P,
        SCAN_B
    } t_scan;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key_value;
        logic signed [31:0] time_stamp;
    } t_in_word;

    typedef struct packed {
        logic [1:0] a_row;
        logic       a_present;
        logic [1:0] b_row;
        logic       b_present;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic  load_a;
        logic  load_b;
        logic  start;
        logic  step;
        logic  finish;
        t_scan mode;
    } t_cmd;

    typedef struct packed {
        logic blocked;
        logic scan_end;
        logic cap;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: hdl/fojtk_ctrl.sv
`default_nettype none

module fojtk_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_op,
    input  wire fojtk_pkg::t_stat i_stat,
    output fojtk_pkg::t_cmd    o_cmd,
    output logic               o_busy
);
    import fojtk_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EMIT_A,
        ST_EMIT_P,
        ST_EMIT_B,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.mode   = SCAN_MATCH;
        o_cmd.load_a = accept && (i_op == OP_LOAD_A);
        o_cmd.load_b = accept && (i_op == OP_LOAD_B);
        o_cmd.start  = accept && (i_op == OP_RUN);
        unique case (r_state)
            ST_IDLE:   o_cmd.mode = SCAN_MATCH;
            ST_MATCH:  begin o_cmd.step = 1'b1; o_cmd.mode = SCAN_MATCH; end
            ST_EMIT_A: begin o_cmd.step = 1'b1; o_cmd.mode = SCAN_A; end
            ST_EMIT_P: begin o_cmd.step = 1'b1; o_cmd.mode = SCAN_P; end
            ST_EMIT_B: begin o_cmd.step = 1'b1; o_cmd.mode = SCAN_B; end
            ST_FINISH: o_cmd.finish = 1'b1;
            default:   o_cmd.mode = SCAN_MATCH;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) n_state = ST_MATCH;
            end
            ST_MATCH: begin
                if (i_stat.scan_end) n_state = ST_EMIT_A;
            end
            ST_EMIT_A, ST_EMIT_P, ST_EMIT_B: begin
                // Reaching the result cap ends the run at once.
                if (!i_stat.blocked) begin
                    if (i_stat.cap) begin
                        n_state = ST_FINISH;
                    end else if (i_stat.scan_end) begin
                        unique case (r_state)
                            ST_EMIT_A: n_state = ST_EMIT_P;
                            ST_EMIT_P: n_state = ST_EMIT_B;
                            default:   n_state = ST_FINISH;
                        endcase
                    end
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && i_stat.out_free) |=> (r_state == ST_IDLE))
        else $error("finish step did not return to idle");

endmodule

`default_nettype wire

FILE: hdl/fojtk_dp.sv
`default_nettype none

module fojtk_dp #(
    parameter int unsigned MAX_ROWS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic signed [31:0] i_key,
    input  wire logic signed [31:0] i_stamp,
    input  wire fojtk_pkg::t_cmd   i_cmd,
    output fojtk_pkg::t_stat       o_stat,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output fojtk_pkg::t_out_word   o_out_word
);
    import fojtk_pkg::*;

    localparam int unsigned IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned CW = $clog2(MAX_ROWS + 1);

    logic [31:0] r_a_keys   [MAX_ROWS];
    logic [31:0] r_a_stamps [MAX_ROWS];
    logic [31:0] r_b_keys   [MAX_ROWS];
    logic [31:0] r_b_stamps [MAX_ROWS];

    logic [CW-1:0]       r_a_count, r_b_count;
    logic [MAX_ROWS-1:0] r_a_matched, r_b_matched;
    logic [CW-1:0]       r_i, r_j;
    logic [NW-1:0]       r_res_cnt;
    logic                r_pend_valid;
    t_out_word           r_pend;
    logic                r_out_valid;
    t_out_word           r_out;

    logic [IW-1:0] ai, bj;
    logic          a_ok, b_ok, eq, hit, emit_mode, out_free, blocked, adv;
    logic          push_pend, fin, a_last, b_last, scan_end;
    logic [CW-1:0] i_inc, j_inc;
    t_out_word     cand;
    logic          n_out_valid;
    t_out_word     n_out;

    assign ai    = r_i[IW-1:0];
    assign bj    = r_j[IW-1:0];
    assign i_inc = r_i + 1'b1;
    assign j_inc = r_j + 1'b1;
    assign a_ok  = (r_i < r_a_count);
    assign b_ok  = (r_j < r_b_count);
    assign eq    = (r_a_keys[ai] == r_b_keys[bj]) && (r_a_stamps[ai] == r_b_stamps[bj]);
    assign a_last = (i_inc >= r_a_count);
    assign b_last = (j_inc >= r_b_count);

    always_comb begin
        cand = '0;
        hit  = 1'b0;
        scan_end = 1'b0;
        unique case (i_cmd.mode)
            SCAN_MATCH: begin
                hit = a_ok && b_ok && eq;
                scan_end = (r_a_count == '0) || (r_b_count == '0) || (a_last && b_last);
            end
            SCAN_A: begin
                hit = a_ok && !r_a_matched[ai];
                scan_end = a_last;
                cand.a_row = 2'(r_i);
                cand.a_present = 1'b1;
            end
            SCAN_P: begin
                hit = a_ok && b_ok && eq;
                scan_end = (r_a_count == '0) || (r_b_count == '0) || (a_last && b_last);
                cand.a_row = 2'(r_i);
                cand.a_present = 1'b1;
                cand.b_row = 2'(r_j);
                cand.b_present = 1'b1;
            end
            SCAN_B: begin
                hit = b_ok && !r_b_matched[bj];
                scan_end = b_last;
                cand.b_row = 2'(r_j);
                cand.b_present = 1'b1;
            end
            default: hit = 1'b0;
        endcase
    end

    assign emit_mode = (i_cmd.mode != SCAN_MATCH);
    assign out_free  = !r_out_valid || !i_out_stall;
    // A second hit may only replace the held result once the output can take it.
    assign blocked   = emit_mode && hit && r_pend_valid && !out_free;
    assign adv       = i_cmd.step && !blocked;
    assign push_pend = adv && emit_mode && hit && r_pend_valid;
    assign fin       = i_cmd.finish && out_free;

    assign o_stat.blocked  = blocked;
    assign o_stat.scan_end = scan_end;
    assign o_stat.cap      = adv && emit_mode && hit && (r_res_cnt == NW'(MAX_RESULTS - 1));
    assign o_stat.out_free = out_free;

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (push_pend) begin
            n_out_valid = 1'b1;
            n_out       = r_pend;
        end else if (fin) begin
            n_out_valid = 1'b1;
            n_out       = r_pend_valid ? r_pend : '0;
            n_out.last  = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_count    <= '0;
            r_b_count    <= '0;
            r_a_matched  <= '0;
            r_b_matched  <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_res_cnt    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cmd.load_a && (r_a_count < CW'(MAX_ROWS))) r_a_count <= r_a_count + 1'b1;
            if (i_cmd.load_b && (r_b_count < CW'(MAX_ROWS))) r_b_count <= r_b_count + 1'b1;
            if (i_cmd.start) begin
                r_a_matched  <= '0;
                r_b_matched  <= '0;
                r_i          <= '0;
                r_j          <= '0;
                r_res_cnt    <= '0;
                r_pend_valid <= 1'b0;
            end else if (adv) begin
                if (i_cmd.mode == SCAN_MATCH && hit) begin
                    r_a_matched[ai] <= 1'b1;
                    r_b_matched[bj] <= 1'b1;
                end
                if (emit_mode && hit) begin
                    r_pend_valid <= 1'b1;
                    r_res_cnt    <= r_res_cnt + 1'b1;
                end
                if (scan_end) begin
                    r_i <= '0;
                    r_j <= '0;
                end else if (i_cmd.mode == SCAN_A) begin
                    r_i <= i_inc;
                end else if (i_cmd.mode == SCAN_B) begin
                    r_j <= j_inc;
                end else if (!b_last) begin
                    r_j <= j_inc;
                end else begin
                    r_j <= '0;
                    r_i <= i_inc;
                end
            end else if (fin) begin
                r_a_count    <= '0;
                r_b_count    <= '0;
                r_a_matched  <= '0;
                r_b_matched  <= '0;
                r_i          <= '0;
                r_j          <= '0;
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (adv && emit_mode && hit) r_pend <= cand;
        if (i_cmd.load_a && (r_a_count < CW'(MAX_ROWS))) begin
            r_a_keys[r_a_count[IW-1:0]]   <= i_key;
            r_a_stamps[r_a_count[IW-1:0]] <= i_stamp;
        end
        if (i_cmd.load_b && (r_b_count < CW'(MAX_ROWS))) begin
            r_b_keys[r_b_count[IW-1:0]]   <= i_key;
            r_b_stamps[r_b_count[IW-1:0]] <= i_stamp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_count <= CW'(MAX_ROWS)) && (r_b_count <= CW'(MAX_ROWS)))
        else $error("table row count beyond capacity");

    a_results_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= NW'(MAX_RESULTS))
        else $error("more results than the cap");

    a_null_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.a_present) |->
            (r_out.a_row == 2'd0) && (r_out.b_present || r_out.last))
        else $error("word with absent A side is malformed");

endmodule

`default_nettype wire

FILE: hdl/full_outer_join_two_keys_top.sv
// Load words are accepted back to back while no run is in progress.
// A run scans row pairs for matches, emits unmatched A rows, matched pairs, unmatched B
// rows, then finishes; it walks one row or row pair per cycle unless the output stalls.
// Each result waits in a holding register until the next result or the finish step
// moves it into the one-word output register, so the final word can carry last.
// Reset is synchronous and active low; it empties both tables and the output.
`default_nettype none

module full_outer_join_two_keys_top #(
    parameter int unsigned MAX_ROWS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire fojtk_pkg::t_in_word   i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output fojtk_pkg::t_out_word       o_out_word
);
    import fojtk_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;

    assign o_in_stall = busy;

    fojtk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_word.operation),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    fojtk_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (i_in_word.key_value),
        .i_stamp     (i_in_word.time_stamp),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
